FILE: hdl/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg: line position estimator shared types
// Beat structs, sample width and the pattern-to-position table.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int SAMPLE_BITS = 15;
  localparam int NUM_SAMPLES = 8;
  localparam int POS_BITS    = 5;

  typedef logic [SAMPLE_BITS-1:0]      sample_t;
  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic [NUM_SAMPLES-1:0]      pattern_t;

  typedef struct packed {
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;
    sample_t sample_7;
  } in_beat_t;

  typedef struct packed {
    pos_t     position_eighths;
    pattern_t bit_pattern;
    logic     recognized;
  } out_beat_t;

  typedef struct packed {
    sample_t [NUM_SAMPLES-1:0] smp;
    sample_t                   lo;
    sample_t                   hi;
  } mm_stage_t;

  typedef struct packed {
    logic hit;
    pos_t pos;
  } pos_lookup_t;

  function automatic pos_lookup_t pos_lookup(input pattern_t pat);
    pos_lookup_t r;
    r.hit = 1'b1;
    r.pos = '0;
    case (pat)
      8'h18:        r.pos = 5'sd0;
      8'h10, 8'h38: r.pos = 5'sd2;
      8'h08, 8'h1C: r.pos = -5'sd2;
      8'h30:        r.pos = 5'sd3;
      8'h0C:        r.pos = -5'sd3;
      8'h20, 8'h70: r.pos = 5'sd4;
      8'h04, 8'h0E: r.pos = -5'sd4;
      8'h60, 8'hE0: r.pos = 5'sd5;
      8'h06, 8'h07: r.pos = -5'sd5;
      8'h40, 8'hF0: r.pos = 5'sd6;
      8'h02, 8'h0F: r.pos = -5'sd6;
      8'hC0:        r.pos = 5'sd7;
      8'h03:        r.pos = -5'sd7;
      8'h80:        r.pos = 5'sd8;
      8'h01:        r.pos = -5'sd8;
      default:      r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/line_position_estimator.sv
// ----------------------------------------------------------------------------
// line_position_estimator: line sensor scan to line position
// Input channel (in_valid, in_stall, in_beat) takes one scan of eight
// samples per beat. Result channel (out_valid, out_stall, out_beat) gives
// one beat per scan: position in eighths (-8..+8), the thresholded pattern
// and a recognized flag.
// A scan passes the input register, the min/max register and the result
// register in turn before its result is valid.
// Throughput: one scan per cycle; the three-register pipeline moves a
// beat every cycle the result side takes one.
// When out_stall is high the result beat holds; empty stages still fill,
// so up to three scans are taken before in_stall rises.
// Patterns outside the table repeat the previous position.
// Reset clears all valid flags and sets the held position to zero.
// ----------------------------------------------------------------------------
module line_position_estimator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpe_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output lpe_pkg::out_beat_t out_beat
);

  lpe_pkg::in_beat_t  in_r;
  logic               in_vld_r;
  logic               mm_rdy;
  logic               mm_vld;
  lpe_pkg::mm_stage_t mm_stage;
  logic               cl_rdy;
  logic               in_adv;

  assign in_adv   = !in_vld_r || mm_rdy;
  assign in_stall = !in_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_r <= in_beat;
    end
  end

  lpe_minmax u_minmax (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_vld_r),
    .beat_i  (in_r),
    .adv_i   (cl_rdy),
    .rdy_o   (mm_rdy),
    .vld_o   (mm_vld),
    .stage_o (mm_stage)
  );

  lpe_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (mm_vld),
    .stage_i   (mm_stage),
    .rdy_o     (cl_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

FILE: hdl/lpe_minmax.sv
// ----------------------------------------------------------------------------
// lpe_minmax: scan extremes stage
// Finds the minimum and maximum of one registered scan and holds them
// with the samples for the classify stage.
// ----------------------------------------------------------------------------
module lpe_minmax (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  lpe_pkg::in_beat_t beat_i,
  input  logic              adv_i,
  output logic              rdy_o,
  output logic              vld_o,
  output lpe_pkg::mm_stage_t stage_o
);

  lpe_pkg::sample_t [lpe_pkg::NUM_SAMPLES-1:0] smp;
  lpe_pkg::sample_t [3:0] lo1, hi1;
  lpe_pkg::sample_t [1:0] lo2, hi2;
  lpe_pkg::mm_stage_t     stage_nxt;
  lpe_pkg::mm_stage_t     stage_r;
  logic                   vld_r;

  assign smp[0] = beat_i.sample_0;
  assign smp[1] = beat_i.sample_1;
  assign smp[2] = beat_i.sample_2;
  assign smp[3] = beat_i.sample_3;
  assign smp[4] = beat_i.sample_4;
  assign smp[5] = beat_i.sample_5;
  assign smp[6] = beat_i.sample_6;
  assign smp[7] = beat_i.sample_7;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lo1[i] = (smp[2*i] < smp[2*i+1]) ? smp[2*i] : smp[2*i+1];
      hi1[i] = (smp[2*i] > smp[2*i+1]) ? smp[2*i] : smp[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      lo2[i] = (lo1[2*i] < lo1[2*i+1]) ? lo1[2*i] : lo1[2*i+1];
      hi2[i] = (hi1[2*i] > hi1[2*i+1]) ? hi1[2*i] : hi1[2*i+1];
    end
    stage_nxt.smp = smp;
    stage_nxt.lo  = (lo2[0] < lo2[1]) ? lo2[0] : lo2[1];
    stage_nxt.hi  = (hi2[0] > hi2[1]) ? hi2[0] : hi2[1];
  end

  assign rdy_o = !vld_r || adv_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign stage_o = stage_r;

  a_lo_le_hi: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> stage_r.lo <= stage_r.hi)
    else $error("minimum above maximum");

endmodule

FILE: hdl/lpe_classify.sv
// ----------------------------------------------------------------------------
// lpe_classify: threshold, pattern and position stage
// Thresholds the scan at the mid level, looks the pattern up and holds
// the last position for patterns outside the table.
// ----------------------------------------------------------------------------
module lpe_classify (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  lpe_pkg::mm_stage_t  stage_i,
  output logic                rdy_o,
  output logic                out_valid,
  input  logic                out_stall,
  output lpe_pkg::out_beat_t  out_beat
);

  lpe_pkg::sample_t    thr;
  lpe_pkg::pattern_t   pat;
  lpe_pkg::pos_lookup_t lk;
  lpe_pkg::out_beat_t  beat_nxt;
  lpe_pkg::out_beat_t  beat_r;
  lpe_pkg::pos_t       last_pos_r;
  logic                out_valid_r;
  logic                load;

  always_comb begin
    thr = stage_i.lo + ((stage_i.hi - stage_i.lo) >> 1);
    for (int i = 0; i < lpe_pkg::NUM_SAMPLES; i++) begin
      pat[lpe_pkg::NUM_SAMPLES-1-i] = (stage_i.smp[i] >= thr);
    end
    lk = lpe_pkg::pos_lookup(pat);
    beat_nxt.bit_pattern      = pat;
    beat_nxt.recognized       = lk.hit;
    beat_nxt.position_eighths = lk.hit ? lk.pos : last_pos_r;
  end

  assign rdy_o = !out_valid_r || !out_stall;
  assign load  = rdy_o && vld_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
    end else begin
      if (rdy_o) begin
        out_valid_r <= vld_i;
      end
      if (load) begin
        last_pos_r <= beat_nxt.position_eighths;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = beat_r;

  a_last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> last_pos_r == beat_r.position_eighths)
    else $error("held position out of step with result");

  a_flat_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && beat_r.bit_pattern == '1 |-> !beat_r.recognized)
    else $error("flat scan reported as recognized");

  a_pattern_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> beat_r.bit_pattern != '0)
    else $error("empty pattern");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && beat_r.recognized |->
      beat_r.position_eighths >= -5'sd8 && beat_r.position_eighths <= 5'sd8)
    else $error("position out of range");

endmodule
